[hdl/crs_pkg.sv]
package crs_pkg;

    localparam int LETTER_W    = 5;
    localparam int NUM_ENTRIES = 26;
    localparam int ACC_W       = 7;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;

    typedef enum logic [1:0] {
        KIND_FWD    = 2'd0,
        KIND_BWD    = 2'd1,
        KIND_ROTATE = 2'd2,
        KIND_RELOAD = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        REG_WIRING_A = 3'd0,
        REG_WIRING_B = 3'd1,
        REG_WIRING_C = 3'd2,
        REG_NOTCH    = 3'd3,
        REG_START    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_MOD,
        ST_VAL_MOD,
        ST_SCAN,
        ST_OUT_MOD,
        ST_OUT
    } state_t;

    typedef struct packed {
        kind_t                 kind;
        logic [LETTER_W-1:0]   letter_in;
        logic [LETTER_W-1:0]   rot_amount;
    } crs_in_t;

    typedef struct packed {
        logic [LETTER_W-1:0]   letter_out;
        logic                  step_neighbor;
        logic                  not_found;
    } crs_out_t;

    typedef struct packed {
        logic [NUM_ENTRIES-1:0] notch_mask;
        logic [LETTER_W-1:0]    start_position;
    } crs_cfg_t;

endpackage

[hdl/crs_regs.sv]
module crs_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [crs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [crs_pkg::CFG_DATA_W-1:0]    prdata,
    input  logic [crs_pkg::LETTER_W-1:0]      rd_idx,
    output logic [crs_pkg::LETTER_W-1:0]      rd_entry,
    output crs_pkg::crs_cfg_t                 cfg
);

    localparam int EW = crs_pkg::LETTER_W;
    localparam int NE = crs_pkg::NUM_ENTRIES;
    localparam int DW = crs_pkg::CFG_DATA_W;

    logic [59:0]   wiring_a_reg, wiring_a_next;
    logic [59:0]   wiring_b_reg, wiring_b_next;
    logic [9:0]    wiring_c_reg, wiring_c_next;
    logic [NE-1:0] notch_reg, notch_next;
    logic [EW-1:0] start_reg, start_next;

    logic                 wr_en;
    crs_pkg::reg_idx_t    addr_idx;
    logic [NE*EW-1:0]     wire_bits;

    assign wr_en    = psel & penable & pwrite;
    assign addr_idx = crs_pkg::reg_idx_t'(paddr[5:3]);

    always_comb begin
        wiring_a_next = wiring_a_reg;
        wiring_b_next = wiring_b_reg;
        wiring_c_next = wiring_c_reg;
        notch_next    = notch_reg;
        start_next    = start_reg;
        if (wr_en) begin
            unique case (addr_idx)
                crs_pkg::REG_WIRING_A: wiring_a_next = pwdata[59:0];
                crs_pkg::REG_WIRING_B: wiring_b_next = pwdata[59:0];
                crs_pkg::REG_WIRING_C: wiring_c_next = pwdata[9:0];
                crs_pkg::REG_NOTCH:    notch_next    = pwdata[NE-1:0];
                crs_pkg::REG_START:    start_next    = pwdata[EW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wiring_a_reg <= '0;
            wiring_b_reg <= '0;
            wiring_c_reg <= '0;
            notch_reg    <= '0;
            start_reg    <= '0;
        end else begin
            wiring_a_reg <= wiring_a_next;
            wiring_b_reg <= wiring_b_next;
            wiring_c_reg <= wiring_c_next;
            notch_reg    <= notch_next;
            start_reg    <= start_next;
        end
    end

    always_comb begin
        unique case (addr_idx)
            crs_pkg::REG_WIRING_A: prdata = DW'(wiring_a_reg);
            crs_pkg::REG_WIRING_B: prdata = DW'(wiring_b_reg);
            crs_pkg::REG_WIRING_C: prdata = DW'(wiring_c_reg);
            crs_pkg::REG_NOTCH:    prdata = DW'(notch_reg);
            crs_pkg::REG_START:    prdata = DW'(start_reg);
            default:               prdata = '0;
        endcase
    end

    // single read port into the wiring table, entry 0 in the low bits
    assign wire_bits = {wiring_c_reg, wiring_b_reg, wiring_a_reg};
    assign rd_entry  = (int'(rd_idx) < NE) ? wire_bits[int'(rd_idx)*EW +: EW] : '0;

    assign cfg.notch_mask     = notch_reg;
    assign cfg.start_position = start_reg;

endmodule

[hdl/cipher_rotor_stage.sv]
// Forward item: the key (letter plus offset) is reduced, the wiring entry is read and reduced,
// the offset is taken back off and the sum is reduced. A backward item scans one wiring entry per cycle.
// Each modulo reduction uses one shared compare-and-subtract step per cycle (more steps
// at small alphabets). One item in flight: the next is accepted while a result waits.
// Reset (aresetn low, synchronous) clears the config registers, the state, the rotation offset and m_valid.
module cipher_rotor_stage #(
    parameter int ALPHABET_SIZE = 26
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  crs_pkg::crs_in_t                  s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output crs_pkg::crs_out_t                 m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [crs_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [crs_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [crs_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int AW = crs_pkg::ACC_W;
    localparam int LW = crs_pkg::LETTER_W;
    localparam logic [AW-1:0] N_ACC    = AW'(ALPHABET_SIZE);
    localparam logic [LW-1:0] LAST_IDX = LW'(ALPHABET_SIZE - 1);

    crs_pkg::state_t   state_reg, state_next;
    crs_pkg::kind_t    kind_reg, kind_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [LW-1:0]     target_reg, target_next;
    logic [LW-1:0]     idx_reg, idx_next;
    logic [LW-1:0]     offset_reg, offset_next;
    crs_pkg::crs_out_t pend_reg, pend_next;
    crs_pkg::crs_out_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    crs_pkg::crs_cfg_t cfg;
    logic [LW-1:0]     rd_idx;
    logic [LW-1:0]     rd_entry;

    // shared arithmetic: one compare-and-subtract plus one adder
    logic [AW-1:0]     add_a, add_b, sum;
    logic [AW-1:0]     acc_red;
    logic              acc_ge;
    logic [AW-1:0]     n_minus_off;
    logic              hit;
    logic              accept;
    logic              out_free;

    crs_regs u_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .rd_idx   (rd_idx),
        .rd_entry (rd_entry),
        .cfg      (cfg)
    );

    assign pready      = 1'b1;
    assign s_ready     = (state_reg == crs_pkg::ST_IDLE);
    assign accept      = s_valid & s_ready;
    assign out_free    = !out_valid_reg || m_ready;
    assign acc_ge      = (acc_reg >= N_ACC);
    assign acc_red     = acc_reg - N_ACC;
    assign n_minus_off = N_ACC - AW'(offset_reg);
    assign sum         = add_a + add_b;
    assign rd_idx      = (state_reg == crs_pkg::ST_SCAN) ? idx_reg : acc_reg[LW-1:0];
    assign hit         = (rd_entry == target_reg);

    always_comb begin
        add_a = acc_reg;
        add_b = n_minus_off;
        unique case (state_reg)
            crs_pkg::ST_IDLE: begin
                case (s_data.kind) inside
                    crs_pkg::KIND_FWD, crs_pkg::KIND_BWD: begin
                        add_a = AW'(s_data.letter_in);
                        add_b = AW'(offset_reg);
                    end
                    crs_pkg::KIND_ROTATE: begin
                        add_a = AW'(s_data.rot_amount);
                        add_b = AW'(offset_reg);
                    end
                    default: begin
                        add_a = AW'(cfg.start_position);
                        add_b = '0;
                    end
                endcase
            end
            crs_pkg::ST_SCAN: add_a = AW'(idx_reg);
            default: ;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            crs_pkg::ST_IDLE:
                if (s_valid) state_next = crs_pkg::ST_KEY_MOD;
            crs_pkg::ST_KEY_MOD:
                if (!acc_ge) begin
                    case (kind_reg) inside
                        crs_pkg::KIND_FWD: state_next = crs_pkg::ST_VAL_MOD;
                        crs_pkg::KIND_BWD: state_next = crs_pkg::ST_SCAN;
                        default:           state_next = crs_pkg::ST_OUT;
                    endcase
                end
            crs_pkg::ST_VAL_MOD:
                if (!acc_ge) state_next = crs_pkg::ST_OUT_MOD;
            crs_pkg::ST_SCAN:
                if (hit) begin
                    state_next = crs_pkg::ST_OUT_MOD;
                end else if (idx_reg == LAST_IDX) begin
                    state_next = crs_pkg::ST_OUT;
                end
            crs_pkg::ST_OUT_MOD:
                if (!acc_ge) state_next = crs_pkg::ST_OUT;
            crs_pkg::ST_OUT:
                if (out_free) state_next = crs_pkg::ST_IDLE;
            default: state_next = crs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        kind_next      = kind_reg;
        acc_next       = acc_reg;
        target_next    = target_reg;
        idx_next       = idx_reg;
        offset_next    = offset_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        unique case (state_reg)
            crs_pkg::ST_IDLE:
                if (accept) begin
                    kind_next               = s_data.kind;
                    acc_next                = sum;
                    pend_next.letter_out    = '0;
                    pend_next.not_found     = 1'b0;
                    pend_next.step_neighbor = (s_data.kind == crs_pkg::KIND_FWD) &&
                                              cfg.notch_mask[offset_reg];
                end
            crs_pkg::ST_KEY_MOD:
                if (acc_ge) begin
                    acc_next = acc_red;
                end else begin
                    case (kind_reg) inside
                        crs_pkg::KIND_FWD: acc_next = AW'(rd_entry);
                        crs_pkg::KIND_BWD: begin
                            target_next = acc_reg[LW-1:0];
                            idx_next    = '0;
                        end
                        default: offset_next = acc_reg[LW-1:0];
                    endcase
                end
            crs_pkg::ST_VAL_MOD:
                acc_next = acc_ge ? acc_red : sum;
            crs_pkg::ST_SCAN:
                if (hit) begin
                    acc_next = sum;
                end else if (idx_reg == LAST_IDX) begin
                    pend_next.not_found = 1'b1;
                end else begin
                    idx_next = idx_reg + LW'(1);
                end
            crs_pkg::ST_OUT_MOD:
                if (acc_ge) begin
                    acc_next = acc_red;
                end else begin
                    pend_next.letter_out = acc_reg[LW-1:0];
                end
            crs_pkg::ST_OUT:
                // hand over to the output register once it is free
                if (out_free) begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= crs_pkg::ST_IDLE;
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            offset_reg    <= offset_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        acc_reg    <= acc_next;
        target_reg <= target_next;
        idx_reg    <= idx_next;
        pend_reg   <= pend_next;
        out_reg    <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[hdl/crs_checker.sv]
module crs_checker #(
    parameter int ALPHABET_SIZE = 26
) (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input crs_pkg::crs_out_t                 m_data
);

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item was still in work");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    a_letter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (int'(m_data.letter_out) < ALPHABET_SIZE))
        else $error("result letter outside the alphabet");

    a_miss_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.not_found |-> !m_data.step_neighbor && m_data.letter_out == '0)
        else $error("miss result carries a letter or a step flag");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("block not idle after reset");

endmodule

bind cipher_rotor_stage crs_checker #(.ALPHABET_SIZE(ALPHABET_SIZE)) u_crs_checker (.*);

[tb/cipher_rotor_stage_tb.sv]
`timescale 1ns / 100ps

module cipher_rotor_stage_tb;

    localparam int ALPHABET       = 26;
    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int DRAIN_CYCLES   = ALPHABET + 14;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 172;
    localparam int REG_SPARE      = 5;

    // Shadow of the rotor: register copies, rotation offset and the letters still owed.
    class rotor_shadow;
        logic [59:0]       wiring_a;
        logic [59:0]       wiring_b;
        logic [9:0]        wiring_c;
        logic [25:0]       notch_mask;
        logic [4:0]        start_position;
        logic [4:0]        rotation_offset;
        crs_pkg::crs_out_t owed_letters[$];
        int                errors;
        int                checked;
        int                kind_count[4];
        int                misses;
        int                steps;

        function new();
            wiring_a        = '0;
            wiring_b        = '0;
            wiring_c        = '0;
            notch_mask      = '0;
            start_position  = '0;
            rotation_offset = '0;
            errors          = 0;
            checked         = 0;
            misses          = 0;
            steps           = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                crs_pkg::REG_WIRING_A: wiring_a       = value[59:0];
                crs_pkg::REG_WIRING_B: wiring_b       = value[59:0];
                crs_pkg::REG_WIRING_C: wiring_c       = value[9:0];
                crs_pkg::REG_NOTCH:    notch_mask     = value[25:0];
                crs_pkg::REG_START:    start_position = value[4:0];
                default: ;
            endcase
        endfunction

        function int wire_entry(int idx);
            if (idx < 12)
                return wiring_a[5*idx +: 5];
            if (idx < 24)
                return wiring_b[5*(idx-12) +: 5];
            return wiring_c[5*(idx-24) +: 5];
        endfunction

        function int pending();
            return owed_letters.size();
        endfunction

        function void note_item(crs_pkg::crs_in_t item);
            crs_pkg::crs_out_t want;
            int                off;
            int                key;
            int                val;
            bit                hit;
            want = '0;
            off  = rotation_offset;
            kind_count[item.kind]++;
            case (item.kind)
                crs_pkg::KIND_FWD: begin
                    key = (int'(item.letter_in) + off) % ALPHABET;
                    val = wire_entry(key) % ALPHABET;
                    want.letter_out    = 5'((val + ALPHABET - off) % ALPHABET);
                    want.step_neighbor = notch_mask[off];
                    steps += want.step_neighbor;
                end
                crs_pkg::KIND_BWD: begin
                    key = (int'(item.letter_in) + off) % ALPHABET;
                    hit = 1'b0;
                    // lowest matching entry wins; out-of-range entries never match
                    for (int i = 0; i < ALPHABET; i++) begin
                        if (!hit && wire_entry(i) == key) begin
                            hit = 1'b1;
                            want.letter_out = 5'((i + ALPHABET - off) % ALPHABET);
                        end
                    end
                    want.not_found = !hit;
                    misses += want.not_found;
                end
                crs_pkg::KIND_ROTATE:
                    rotation_offset = 5'((off + int'(item.rot_amount)) % ALPHABET);
                default:
                    rotation_offset = 5'(int'(start_position) % ALPHABET);
            endcase
            owed_letters.push_back(want);
        endfunction

        function void check_letter(crs_pkg::crs_out_t got);
            crs_pkg::crs_out_t want;
            if (owed_letters.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d step %0b miss %0b",
                         $time, got.letter_out, got.step_neighbor, got.not_found);
                return;
            end
            want = owed_letters.pop_front();
            checked++;
            if (got.letter_out !== want.letter_out) begin
                errors++;
                $display("%0t: letter_out mismatch, expected %0d, actual %0d",
                         $time, want.letter_out, got.letter_out);
            end
            if (got.step_neighbor !== want.step_neighbor) begin
                errors++;
                $display("%0t: step_neighbor mismatch, expected %0b, actual %0b",
                         $time, want.step_neighbor, got.step_neighbor);
            end
            if (got.not_found !== want.not_found) begin
                errors++;
                $display("%0t: not_found mismatch, expected %0b, actual %0b",
                         $time, want.not_found, got.not_found);
            end
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    crs_pkg::crs_in_t               s_data;
    logic                           m_valid;
    logic                           m_ready;
    crs_pkg::crs_out_t              m_data;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [crs_pkg::CFG_ADDR_W-1:0] paddr;
    logic [crs_pkg::CFG_DATA_W-1:0] pwdata;
    logic [crs_pkg::CFG_DATA_W-1:0] prdata;
    logic                           pready;

    rotor_shadow shadow = new();
    logic [4:0]  wiring_tbl [ALPHABET];
    bit          idle_on     = 1'b1;
    int          hold_cycles = 0;
    int          stalled     = 0;
    int          settings    = 0;

    cipher_rotor_stage #(
        .ALPHABET_SIZE(ALPHABET)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD/2) aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                shadow.check_letter(m_data);
            if (s_valid && s_ready)
                shadow.note_item(s_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stalled <= 0;
        else
            stalled <= stalled + 1;
        if (stalled >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, stalled);
            $display("cipher_rotor_stage test failed");
            $finish;
        end
    end

    // Result side: long hold on request, otherwise short random stalls.
    initial begin
        int stall_left;
        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic crs_pkg::crs_in_t mk(crs_pkg::kind_t kind, int letter, int shift);
        crs_pkg::crs_in_t item;
        item.kind       = kind;
        item.letter_in  = 5'(letter);
        item.rot_amount = 5'(shift);
        return item;
    endfunction

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input crs_pkg::crs_in_t item);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (s_ready !== 1'b1);
        @(negedge aclk);
    endtask

    task automatic stop_items();
        s_valid <= 1'b0;
    endtask

    task automatic settle();
        while (shadow.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        shadow.write_reg(idx, value);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Pack the wiring table; unused upper bits carry noise that must be dropped.
    task automatic write_config(input logic [25:0] notch, input logic [4:0] start);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] noise;
        a = {$urandom(), $urandom()};
        b = {$urandom(), $urandom()};
        c = {$urandom(), $urandom()};
        noise = {$urandom(), $urandom()};
        for (int i = 0; i < 12; i++) begin
            a[5*i +: 5] = wiring_tbl[i];
            b[5*i +: 5] = wiring_tbl[i+12];
        end
        c[4:0] = wiring_tbl[24];
        c[9:5] = wiring_tbl[25];
        apb_write(crs_pkg::REG_WIRING_A, a);
        apb_write(crs_pkg::REG_WIRING_B, b);
        apb_write(crs_pkg::REG_WIRING_C, c);
        apb_write(crs_pkg::REG_NOTCH, {noise[63:26], notch});
        apb_write(crs_pkg::REG_START, {noise[63:5], start});
        // an address past the register list must not disturb anything
        apb_write(3'($urandom_range(REG_SPARE, 7)), {$urandom(), $urandom()});
        settings++;
    endtask

    initial begin
        crs_pkg::crs_in_t item;
        int               pick;
        int               j;
        logic [4:0]       tmp;
        s_valid = 1'b0;
        s_data  = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        aresetn = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: near-permutation with out-of-range entries and one duplicate.
        for (int i = 0; i < ALPHABET; i++) wiring_tbl[i] = 5'((7*i + 3) % ALPHABET);
        wiring_tbl[5]  = 5'd31;
        wiring_tbl[25] = 5'd27;
        wiring_tbl[20] = wiring_tbl[2];
        write_config(26'h2000011, 5'd30);
        send_item(mk(crs_pkg::KIND_FWD, 0, 0));
        send_item(mk(crs_pkg::KIND_FWD, 31, 31));
        send_item(mk(crs_pkg::KIND_FWD, 25, 0));
        send_item(mk(crs_pkg::KIND_BWD, 12, 0));
        send_item(mk(crs_pkg::KIND_BWD, 17, 0));
        send_item(mk(crs_pkg::KIND_BWD, 31, 0));
        send_item(mk(crs_pkg::KIND_BWD, 0, 31));
        send_item(mk(crs_pkg::KIND_ROTATE, 31, 25));
        send_item(mk(crs_pkg::KIND_FWD, 25, 0));
        send_item(mk(crs_pkg::KIND_BWD, 1, 0));
        send_item(mk(crs_pkg::KIND_ROTATE, 0, 31));
        send_item(mk(crs_pkg::KIND_FWD, 0, 0));
        send_item(mk(crs_pkg::KIND_ROTATE, 0, 0));
        send_item(mk(crs_pkg::KIND_RELOAD, 31, 31));
        send_item(mk(crs_pkg::KIND_ROTATE, 0, 22));
        send_item(mk(crs_pkg::KIND_FWD, 30, 0));
        send_item(mk(crs_pkg::KIND_RELOAD, 0, 0));
        send_item(mk(crs_pkg::KIND_BWD, 21, 0));
        send_item(mk(crs_pkg::KIND_BWD, 26, 0));
        stop_items();
        settle();

        for (int phase = 0; phase < N_PHASES; phase++) begin
            idle_on = (phase != N_PHASES - 1) && (phase % 3 != 2);
            if (phase == 0) begin
                foreach (wiring_tbl[i]) wiring_tbl[i] = '0;
                write_config('0, '0);
            end else if (phase == 1) begin
                foreach (wiring_tbl[i]) wiring_tbl[i] = '1;
                write_config('1, '1);
            end else begin
                foreach (wiring_tbl[i]) wiring_tbl[i] = 5'(i);
                for (int i = ALPHABET - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    tmp = wiring_tbl[i];
                    wiring_tbl[i] = wiring_tbl[j];
                    wiring_tbl[j] = tmp;
                end
                if (phase % 3 == 1)
                    foreach (wiring_tbl[i]) wiring_tbl[i] = 5'($urandom_range(0, 31));
                else if (phase % 3 == 2)
                    repeat (3)
                        wiring_tbl[$urandom_range(0, ALPHABET - 1)] = 5'($urandom_range(0, 31));
                write_config(26'($urandom()), 5'($urandom_range(0, 31)));
            end

            if (phase == 3) begin
                // hold the result side so the block backs up against the sender
                @(posedge aclk);
                hold_cycles = HOLD_CYCLES;
                @(negedge aclk);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 5 && n == PHASE_ITEMS / 2) begin
                    stop_items();
                    while (shadow.pending() != 0) @(posedge aclk);
                    @(negedge aclk);
                end
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    item.kind = crs_pkg::KIND_FWD;
                else if (pick < 75)
                    item.kind = crs_pkg::KIND_BWD;
                else if (pick < 90)
                    item.kind = crs_pkg::KIND_ROTATE;
                else
                    item.kind = crs_pkg::KIND_RELOAD;
                item.letter_in = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(26, 31))
                                                             : 5'($urandom_range(0, 25));
                item.rot_amount = 5'($urandom_range(0, 31));
                send_item(item);
            end
            stop_items();
            settle();
        end

        $display(
            "Covered %0d forward, %0d backward, %0d rotate, %0d reload items over %0d settings",
            shadow.kind_count[crs_pkg::KIND_FWD], shadow.kind_count[crs_pkg::KIND_BWD],
            shadow.kind_count[crs_pkg::KIND_ROTATE], shadow.kind_count[crs_pkg::KIND_RELOAD],
            settings);
        $display("Checked %0d results: %0d backward misses, %0d notch steps",
                 shadow.checked, shadow.misses, shadow.steps);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("cipher_rotor_stage test passed");
        end else begin
            $display("cipher_rotor_stage test failed");
        end
        $finish;
    end

endmodule

[files.f]
hdl/crs_pkg.sv
hdl/crs_regs.sv
hdl/cipher_rotor_stage.sv
hdl/crs_checker.sv
tb/cipher_rotor_stage_tb.sv
